// File: hdl/ocb_pkg.sv
// ----------------------------------------------------------------------------
// ocb_pkg
// Shared types and constants for the octree cell index block: request and
// response payloads and the register map.
// ----------------------------------------------------------------------------
package ocb_pkg;

   localparam int COORD_W     = 32;
   localparam int CELL_INDEX_W = 25;
   localparam int DEPTH_W     = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEVEL    = 3'd0,
      CSR_ORIGIN_X = 3'd1,
      CSR_ORIGIN_Y = 3'd2,
      CSR_ORIGIN_Z = 3'd3,
      CSR_SCALE_X  = 3'd4,
      CSR_SCALE_Y  = 3'd5,
      CSR_SCALE_Z  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] min_z;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] max_y;
      logic signed [COORD_W-1:0] max_z;
   } req_type;

   typedef struct packed {
      logic [CELL_INDEX_W-1:0] cell_index;
      logic [DEPTH_W-1:0]      node_depth;
   } rsp_type;

endpackage

// File: hdl/ocb_quant.sv
// ----------------------------------------------------------------------------
// ocb_quant
// One axis lane: subtract the origin, then scale to finest cells.
// Two register stages; the integer part of the product leaves the lane.
// ----------------------------------------------------------------------------
module ocb_quant (
   input  logic                              clock,
   input  logic signed [ocb_pkg::COORD_W-1:0] coord,
   input  logic signed [ocb_pkg::COORD_W-1:0] origin,
   input  logic        [ocb_pkg::COORD_W-1:0] scale,
   output logic                              neg,
   output logic        [ocb_pkg::COORD_W-1:0] cell_idx
);
   import ocb_pkg::*;

   logic signed [COORD_W:0]   diff_ff, diff_in;
   logic        [2*COORD_W-1:0] prod;
   logic                      neg_ff, neg_in;
   logic        [COORD_W-1:0] cell_ff, cell_in;

   always_comb begin
      diff_in = {coord[COORD_W-1], coord} - {origin[COORD_W-1], origin};
      prod    = {{COORD_W{1'b0}}, diff_ff[COORD_W-1:0]} * {{COORD_W{1'b0}}, scale};
      neg_in  = diff_ff[COORD_W];
      cell_in = prod[2*COORD_W-1:COORD_W];
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      neg_ff  <= neg_in;
      cell_ff <= cell_in;
   end

   assign neg      = neg_ff;
   assign cell_idx = cell_ff;

endmodule

// File: hdl/ocb_encode.sv
// ----------------------------------------------------------------------------
// ocb_encode
// Clamp the six cells to the active level, interleave each corner into a
// Morton code and register the corner difference with the max corner code.
// ----------------------------------------------------------------------------
module ocb_encode #(
   parameter int MAX_LEVEL = 8
) (
   input  logic                                     clock,
   input  logic [ocb_pkg::DEPTH_W-1:0]              lv,
   input  logic [2:0]                               lo_neg,
   input  logic [2:0][ocb_pkg::COORD_W-1:0]         lo_cell,
   input  logic [2:0]                               hi_neg,
   input  logic [2:0][ocb_pkg::COORD_W-1:0]         hi_cell,
   output logic [3*MAX_LEVEL-1:0]                   diff,
   output logic [3*MAX_LEVEL-1:0]                   hi_code
);
   import ocb_pkg::*;

   logic [MAX_LEVEL-1:0]       cellmax;
   logic [2:0][MAX_LEVEL-1:0]  lo_sat, hi_sat;
   logic [3*MAX_LEVEL-1:0]     lo_code, hi_code_in, diff_in;
   logic [3*MAX_LEVEL-1:0]     diff_ff, hi_code_ff;

   always_comb begin
      cellmax = {MAX_LEVEL{1'b1}} >> (DEPTH_W'(MAX_LEVEL) - lv);
      for (int a = 0; a < 3; a++) begin
         if (lo_neg[a])
            lo_sat[a] = '0;
         else if ((lo_cell[a] >> lv) != '0)
            lo_sat[a] = cellmax;
         else
            lo_sat[a] = lo_cell[a][MAX_LEVEL-1:0];
         if (hi_neg[a])
            hi_sat[a] = '0;
         else if ((hi_cell[a] >> lv) != '0)
            hi_sat[a] = cellmax;
         else
            hi_sat[a] = hi_cell[a][MAX_LEVEL-1:0];
      end
      for (int i = 0; i < MAX_LEVEL; i++) begin
         for (int a = 0; a < 3; a++) begin
            lo_code[3*i+a]    = lo_sat[a][i];
            hi_code_in[3*i+a] = hi_sat[a][i];
         end
      end
      diff_in = lo_code ^ hi_code_in;
   end

   always_ff @(posedge clock) begin
      diff_ff    <= diff_in;
      hi_code_ff <= hi_code_in;
   end

   assign diff    = diff_ff;
   assign hi_code = hi_code_ff;

endmodule

// File: hdl/ocb_depth.sv
// ----------------------------------------------------------------------------
// ocb_depth
// Find the deepest node that holds both corners, then form its linear index
// from the level offset and the max corner code prefix.
// ----------------------------------------------------------------------------
module ocb_depth #(
   parameter int MAX_LEVEL = 8
) (
   input  logic                         clock,
   input  logic [ocb_pkg::DEPTH_W-1:0]  lv,
   input  logic [3*MAX_LEVEL-1:0]       diff,
   input  logic [3*MAX_LEVEL-1:0]       hi_code,
   output ocb_pkg::rsp_type             rsp
);
   import ocb_pkg::*;

   localparam int SH_W = $clog2(3*MAX_LEVEL + 1);

   logic [DEPTH_W-1:0]      shift;
   logic [DEPTH_W-1:0]      depth_ff, depth_in;
   logic [SH_W-1:0]         shift3_ff, shift3_in;
   logic [3*MAX_LEVEL-1:0]  hi_ff;
   logic [CELL_INDEX_W-1:0] offset;
   rsp_type                 rsp_ff, rsp_in;

   always_comb begin
      shift = '0;
      for (int i = 0; i < MAX_LEVEL; i++) begin
         if (diff[3*i +: 3] != 3'b000)
            shift = DEPTH_W'(i + 1);
      end
      depth_in  = lv - shift;
      shift3_in = SH_W'(shift) * SH_W'(3);
   end

   always_ff @(posedge clock) begin
      depth_ff  <= depth_in;
      shift3_ff <= shift3_in;
      hi_ff     <= hi_code;
   end

   always_comb begin
      offset = '0;
      for (int k = 0; k < MAX_LEVEL; k++) begin
         if (DEPTH_W'(k) < depth_ff)
            offset[3*k] = 1'b1;
      end
      rsp_in.cell_index = offset + CELL_INDEX_W'(hi_ff >> shift3_ff);
      rsp_in.node_depth = depth_ff;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

// File: hdl/octree_cell_index_from_box.sv
// ----------------------------------------------------------------------------
// octree_cell_index_from_box
// Linear octree node index and depth of an axis-aligned Q16.16 box.
//
//   channel   ports                          direction
//   request   start, busy, req_data          in (busy out)
//   response  rsp_strobe, rsp_data           out
//   config    csr_we, csr_index, csr_wdata   in
//
// One box accepted per cycle while busy is low; its response strobes once the box has passed the stages below.
// Stages: subtract origin, 32x32 multiply, clamp and interleave,
// depth search, index add. The multiply lanes set the stage depth.
// busy is high in reset and for the cycle after reset only. The response cannot be
// stalled, so the pipeline always advances.
// ----------------------------------------------------------------------------
module octree_cell_index_from_box #(
   parameter int MAX_LEVEL = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ocb_pkg::req_type                  req_data,
   output logic                              rsp_strobe,
   output ocb_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [ocb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ocb_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ocb_pkg::*;

   localparam int STAGES = 5;

   logic [DEPTH_W-1:0]           level_ff;
   logic signed [COORD_W-1:0]    origin_x_ff, origin_y_ff, origin_z_ff;
   logic [COORD_W-1:0]           scale_x_ff, scale_y_ff, scale_z_ff;
   logic [DEPTH_W-1:0]           lv;
   logic                         busy_ff;
   logic [STAGES-1:0]            valid_ff, valid_in;
   logic [2:0]                   lo_neg, hi_neg;
   logic [2:0][COORD_W-1:0]      lo_cell, hi_cell;
   logic [3*MAX_LEVEL-1:0]       diff, hi_code;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= DEPTH_W'(3);
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         scale_x_ff  <= COORD_W'(65536);
         scale_y_ff  <= COORD_W'(65536);
         scale_z_ff  <= COORD_W'(65536);
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEVEL:    level_ff    <= csr_wdata[DEPTH_W-1:0];
            CSR_ORIGIN_X: origin_x_ff <= csr_wdata;
            CSR_ORIGIN_Y: origin_y_ff <= csr_wdata;
            CSR_ORIGIN_Z: origin_z_ff <= csr_wdata;
            CSR_SCALE_X:  scale_x_ff  <= csr_wdata;
            CSR_SCALE_Y:  scale_y_ff  <= csr_wdata;
            CSR_SCALE_Z:  scale_z_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign lv = (level_ff > DEPTH_W'(MAX_LEVEL)) ? DEPTH_W'(MAX_LEVEL) : level_ff;

   assign valid_in = {valid_ff[STAGES-2:0], start & ~busy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         valid_ff <= '0;
      end else begin
         busy_ff  <= 1'b0;
         valid_ff <= valid_in;
      end
   end

   ocb_quant u_lo_x (.clock(clock), .coord(req_data.min_x), .origin(origin_x_ff),
                     .scale(scale_x_ff), .neg(lo_neg[0]), .cell_idx(lo_cell[0]));
   ocb_quant u_lo_y (.clock(clock), .coord(req_data.min_y), .origin(origin_y_ff),
                     .scale(scale_y_ff), .neg(lo_neg[1]), .cell_idx(lo_cell[1]));
   ocb_quant u_lo_z (.clock(clock), .coord(req_data.min_z), .origin(origin_z_ff),
                     .scale(scale_z_ff), .neg(lo_neg[2]), .cell_idx(lo_cell[2]));
   ocb_quant u_hi_x (.clock(clock), .coord(req_data.max_x), .origin(origin_x_ff),
                     .scale(scale_x_ff), .neg(hi_neg[0]), .cell_idx(hi_cell[0]));
   ocb_quant u_hi_y (.clock(clock), .coord(req_data.max_y), .origin(origin_y_ff),
                     .scale(scale_y_ff), .neg(hi_neg[1]), .cell_idx(hi_cell[1]));
   ocb_quant u_hi_z (.clock(clock), .coord(req_data.max_z), .origin(origin_z_ff),
                     .scale(scale_z_ff), .neg(hi_neg[2]), .cell_idx(hi_cell[2]));

   ocb_encode #(.MAX_LEVEL(MAX_LEVEL)) u_encode (
      .clock   (clock),
      .lv      (lv),
      .lo_neg  (lo_neg),
      .lo_cell (lo_cell),
      .hi_neg  (hi_neg),
      .hi_cell (hi_cell),
      .diff    (diff),
      .hi_code (hi_code)
   );

   ocb_depth #(.MAX_LEVEL(MAX_LEVEL)) u_depth (
      .clock   (clock),
      .lv      (lv),
      .diff    (diff),
      .hi_code (hi_code),
      .rsp     (rsp_data)
   );

   assign busy       = busy_ff;
   assign rsp_strobe = valid_ff[STAGES-1];

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the octree cell index block. Boxes are sent
// through the start/busy request port, each response is compared field by
// field with a bit-accurate model of quantise, interleave and depth search,
// under reset defaults, extreme register settings and random phases.
// ----------------------------------------------------------------------------
module tb_top;
   import ocb_pkg::*;

   localparam int MAX_LEVEL   = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 8;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   req_type                req_data = '0;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic [3:0]  cfg_level    = 4'd3;
   logic [31:0] cfg_origin_x = '0;
   logic [31:0] cfg_origin_y = '0;
   logic [31:0] cfg_origin_z = '0;
   logic [31:0] cfg_scale_x  = 32'h0001_0000;
   logic [31:0] cfg_scale_y  = 32'h0001_0000;
   logic [31:0] cfg_scale_z  = 32'h0001_0000;

   rsp_type pending_nodes[$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   bit      idle_enable = 1'b1;

   octree_cell_index_from_box #(.MAX_LEVEL(MAX_LEVEL)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int unsigned level_in_use();
      return (cfg_level > MAX_LEVEL) ? MAX_LEVEL : cfg_level;
   endfunction

   function automatic logic [7:0] axis_cell(logic [31:0] coord, logic [31:0] org,
                                            logic [31:0] scl, int unsigned lv);
      logic [32:0] delta;
      logic [63:0] prod;
      logic [31:0] cell_val;
      logic [31:0] cell_max;
      delta = {coord[31], coord} - {org[31], org};
      if (delta[32]) return 8'd0;
      prod = {32'd0, delta[31:0]} * {32'd0, scl};
      cell_val = prod[63:32];
      cell_max = (32'd1 << lv) - 32'd1;
      if (cell_val > cell_max) cell_val = cell_max;
      return cell_val[7:0];
   endfunction

   function automatic logic [23:0] interleave3(logic [7:0] cx, logic [7:0] cy,
                                               logic [7:0] cz);
      logic [23:0] code;
      int          b;
      code = '0;
      for (b = 0; b < 8; b++) begin
         code[3*b]   = cx[b];
         code[3*b+1] = cy[b];
         code[3*b+2] = cz[b];
      end
      return code;
   endfunction

   function automatic rsp_type predict_node(req_type box);
      int unsigned lv;
      int unsigned shift;
      int unsigned depth;
      int          i;
      logic [23:0] lo_code;
      logic [23:0] hi_code;
      logic [23:0] split;
      logic [31:0] offset;
      rsp_type     node;
      lv = level_in_use();
      lo_code = interleave3(axis_cell(box.min_x, cfg_origin_x, cfg_scale_x, lv),
                            axis_cell(box.min_y, cfg_origin_y, cfg_scale_y, lv),
                            axis_cell(box.min_z, cfg_origin_z, cfg_scale_z, lv));
      hi_code = interleave3(axis_cell(box.max_x, cfg_origin_x, cfg_scale_x, lv),
                            axis_cell(box.max_y, cfg_origin_y, cfg_scale_y, lv),
                            axis_cell(box.max_z, cfg_origin_z, cfg_scale_z, lv));
      split = lo_code ^ hi_code;
      shift = 0;
      for (i = 0; i < lv; i++) begin
         if (split[3*i +: 3] != 3'd0) shift = i + 1;
      end
      depth = lv - shift;
      offset = '0;
      for (i = 0; i < depth; i++) offset = offset * 32'd8 + 32'd1;
      node.cell_index = CELL_INDEX_W'(offset + {8'd0, hi_code >> (3 * shift)});
      node.node_depth = DEPTH_W'(depth);
      return node;
   endfunction

   function automatic req_type make_box(logic [31:0] min_x, logic [31:0] min_y,
                                        logic [31:0] min_z, logic [31:0] max_x,
                                        logic [31:0] max_y, logic [31:0] max_z);
      req_type box;
      box.min_x = min_x;
      box.min_y = min_y;
      box.min_z = min_z;
      box.max_x = max_x;
      box.max_y = max_y;
      box.max_z = max_z;
      return box;
   endfunction

   function automatic void random_axis(logic [31:0] org, logic [31:0] scl,
                                       output logic [31:0] lo, output logic [31:0] hi);
      logic [63:0] span;
      logic [31:0] ext;
      logic [31:0] tmp;
      int unsigned pick;
      span = (scl == 32'd0) ? 64'h7FFF_FFFF : ((64'd1 << (level_in_use() + 32)) / scl);
      if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         lo = org + $urandom_range(0, span[31:0]);
         ext = $urandom_range(0, span[31:0] >> $urandom_range(0, 12));
         hi = lo + ext;
         if (pick >= 70) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
         end
      end else if (pick < 92) begin
         lo = $urandom;
         hi = $urandom;
      end else begin
         case ($urandom_range(0, 4))
            0: lo = 32'h8000_0000;
            1: lo = 32'h7FFF_FFFF;
            2: lo = org;
            3: lo = org - 32'd1;
            default: lo = '0;
         endcase
         hi = (pick < 96) ? lo + $urandom_range(0, 4) : $urandom;
      end
   endfunction

   function automatic req_type random_box();
      logic [31:0] lo[3];
      logic [31:0] hi[3];
      random_axis(cfg_origin_x, cfg_scale_x, lo[0], hi[0]);
      random_axis(cfg_origin_y, cfg_scale_y, lo[1], hi[1]);
      random_axis(cfg_origin_z, cfg_scale_z, lo[2], hi[2]);
      return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
   endfunction

   task automatic send_box(req_type box);
      if (idle_enable && $urandom_range(0, 99) < 3) begin
         repeat ($urandom_range(1, 4)) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_data <= box;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_nodes = {pending_nodes, predict_node(box)};
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_nodes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_LEVEL:    cfg_level    = value[3:0];
         CSR_ORIGIN_X: cfg_origin_x = value;
         CSR_ORIGIN_Y: cfg_origin_y = value;
         CSR_ORIGIN_Z: cfg_origin_z = value;
         CSR_SCALE_X:  cfg_scale_x  = value;
         CSR_SCALE_Y:  cfg_scale_y  = value;
         CSR_SCALE_Z:  cfg_scale_z  = value;
         default: ;
      endcase
   endtask

   task automatic apply_config(logic [31:0] lvl_word, logic [31:0] ox, logic [31:0] oy,
                               logic [31:0] oz, logic [31:0] sx, logic [31:0] sy,
                               logic [31:0] sz);
      wait_idle();
      write_csr(CSR_LEVEL, lvl_word);
      write_csr(CSR_ORIGIN_X, ox);
      write_csr(CSR_ORIGIN_Y, oy);
      write_csr(CSR_ORIGIN_Z, oz);
      write_csr(CSR_SCALE_X, sx);
      write_csr(CSR_SCALE_Y, sy);
      write_csr(CSR_SCALE_Z, sz);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      send_box(make_box(0, 0, 0, 0, 0, 0));
      send_box(make_box(0, 0, 0, 32'h0007_8000, 32'h0007_8000, 32'h0007_8000));
      send_box(make_box(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                        32'h0001_8000, 32'h0002_8000, 32'h0003_8000));
      send_box(make_box(32'hFFFB_0000, 32'hFFFB_0000, 32'hFFFB_0000,
                        32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_0000));
      send_box(make_box(32'h0064_0000, 32'h0064_0000, 32'h0064_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_box(make_box(32'h0006_0000, 32'h0006_0000, 32'h0006_0000,
                        32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
      send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_box(make_box(32'h0003_0000, 0, 0, 32'h0004_0000, 0, 0));
      send_box(make_box(0, 32'h0005_0000, 32'h0002_FFFF,
                        0, 32'h0005_FFFF, 32'h0003_0000));
   endtask

   task automatic test_register_extremes();
      apply_config(32'd0, 32'h0001_0000, 32'hFFFF_0000, 0, 32'h0000_1000,
                   32'hFFFF_FFFF, 32'h0001_0000);
      send_box(make_box(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0));
      send_box(make_box(0, 0, 0, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000));
      apply_config(32'd8, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_box(make_box(32'h8000_0000, 32'h8000_0001, 32'h8000_0002,
                        32'h8000_0002, 32'h8000_0001, 32'h8000_0000));
      send_box(make_box(32'h8000_00FE, 32'h8000_0080, 32'h8000_0010,
                        32'h8000_00FF, 32'h8000_0081, 32'h8000_0011));
      apply_config(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
      send_box(make_box(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
      send_box(make_box(0, 0, 0, 0, 0, 0));
      apply_config(32'd9, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_box(make_box(0, 0, 0, 32'h00FF_0000, 32'h00FF_0000, 32'h00FF_0000));
      send_box(make_box(32'h0080_0000, 32'h0040_0000, 32'h0020_0000,
                        32'h0080_8000, 32'h0040_8000, 32'h0020_8000));
      send_box(make_box(32'h0100_0000, 0, 0, 32'h0200_0000, 0, 0));
      apply_config(32'hABCD_EF01, 32'hFFFF_8000, 0, 32'h0000_8000, 32'h0000_8000,
                   32'h0002_0000, 32'h0001_0000);
      send_box(make_box(32'hFFFF_8000, 0, 32'h0000_8000, 32'h0002_7FFF, 32'h0000_7FFF,
                        32'h0001_7FFF));
      send_box(make_box(32'h0001_0000, 32'h0000_8000, 32'h0001_8000,
                        32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000));
   endtask

   task automatic test_random_phases();
      int          phase;
      int          n;
      logic [31:0] lvl_word;
      logic [31:0] org[3];
      logic [31:0] scl[3];
      int          a;
      for (phase = 0; phase < 8; phase++) begin
         lvl_word = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(0, 15);
         if ($urandom_range(0, 3) == 0) lvl_word = lvl_word | ($urandom & 32'hFFFF_FFF0);
         for (a = 0; a < 3; a++) begin
            org[a] = $urandom_range(0, 1) ? $urandom
                                          : $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
            case ($urandom_range(0, 2))
               0: scl[a] = 32'h0001_0000 << $urandom_range(0, 6);
               1: scl[a] = $urandom;
               default: scl[a] = $urandom_range(1, 32'h0004_0000);
            endcase
         end
         apply_config(lvl_word, org[0], org[1], org[2], scl[0], scl[1], scl[2]);
         idle_enable = (phase != 2);
         for (n = 0; n < 235; n++) send_box(random_box());
      end
      idle_enable = 1'b1;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_nodes.size() == 0) begin
            $error("unexpected response cell_index %0d node_depth %0d",
                   rsp_data.cell_index, rsp_data.node_depth);
            mismatch_count++;
         end else begin
            want = pending_nodes.pop_front();
            if (rsp_data.cell_index !== want.cell_index) begin
               $error("cell_index expected %0d actual %0d", want.cell_index,
                      rsp_data.cell_index);
               mismatch_count++;
            end
            if (rsp_data.node_depth !== want.node_depth) begin
               $error("node_depth expected %0d actual %0d", want.node_depth,
                      rsp_data.node_depth);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_register_extremes();
      test_random_phases();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
